@@ design/sample_filter_resonator_clip_defines.svh @@
// assertion macros for the filter and resonator chain
`ifndef SAMPLE_FILTER_RESONATOR_CLIP_DEFINES_SVH
`define SAMPLE_FILTER_RESONATOR_CLIP_DEFINES_SVH

// same-cycle implication
`define SFRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sfrc_pkg.sv @@
package sfrc_pkg;

  localparam int unsigned SAMPLE_RATE = 44100;

  localparam logic [63:0] SR          = 64'(SAMPLE_RATE);
  localparam logic [63:0] HALF_SR     = SR / 2;
  localparam logic [63:0] W_FILT      = 64'(2 * SAMPLE_RATE) << 16;
  localparam logic [63:0] TWO_PI_Q16  = 64'd411774;
  localparam logic [63:0] TWO_PI_Q24  = 64'd105414358;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q24     = 64'd16777216;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  localparam int unsigned UNIT_STEPS   = 64;
  localparam int unsigned UNIT_CNT_W   = $clog2(UNIT_STEPS);
  localparam int unsigned SERIES_TERMS = 5;
  localparam int unsigned SERIES_W     = $clog2(SERIES_TERMS);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESO_EN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP        = 2'd3;

  localparam logic [1:0] MODE_LOWPASS  = 2'd1;
  localparam logic [1:0] MODE_HIGHPASS = 2'd2;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_F_FC,
    ST_F_B1,
    ST_F_A0,
    ST_F_M0,
    ST_F_M1,
    ST_F_M2,
    ST_F_Y,
    ST_R_W,
    ST_R_WD,
    ST_R_INV,
    ST_R_TURN,
    ST_R_QUOT,
    ST_R_R,
    ST_C_X,
    ST_C_X2,
    ST_C_MUL,
    ST_C_DIV,
    ST_C_SX,
    ST_C_FIN,
    ST_R_C,
    ST_R_V1,
    ST_R_P,
    ST_R_V2,
    ST_G_MUL,
    ST_OUT
  } step_e;

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? $unsigned(-v) : $unsigned(v);
  endfunction

  function automatic logic signed [63:0] sx32(input logic signed [31:0] v);
    return $signed({{32{v[31]}}, v});
  endfunction

  function automatic logic signed [63:0] apply_sign(input logic [63:0] m, input logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] rnd_u(input logic [63:0] m, input int unsigned n);
    return (m + (64'd1 << (n - 1))) >> n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // k(k-1) of the cosine and sine series, highest term first
  function automatic logic [63:0] series_div(input logic sin, input logic [SERIES_W-1:0] k);
    logic [63:0] d;
    case ({sin, k})
      {1'b0, 3'd0}: d = 64'd90;
      {1'b0, 3'd1}: d = 64'd56;
      {1'b0, 3'd2}: d = 64'd30;
      {1'b0, 3'd3}: d = 64'd12;
      {1'b0, 3'd4}: d = 64'd2;
      {1'b1, 3'd0}: d = 64'd110;
      {1'b1, 3'd1}: d = 64'd72;
      {1'b1, 3'd2}: d = 64'd42;
      {1'b1, 3'd3}: d = 64'd20;
      {1'b1, 3'd4}: d = 64'd6;
      default:      d = 64'd1;
    endcase
    return d;
  endfunction

endpackage

@@ design/sfrc_in_if.sv @@
interface sfrc_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] in_sample;
  logic [15:0]        cutoff_freq;
  logic [15:0]        reso_freq;
  logic [15:0]        reso_amount;

  modport source (output valid, in_sample, cutoff_freq, reso_freq, reso_amount,
                  input ready);
  modport sink (input valid, in_sample, cutoff_freq, reso_freq, reso_amount,
                output ready);
endinterface

@@ design/sfrc_out_if.sv @@
interface sfrc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] out_sample;

  modport source (output valid, out_sample, input ready);
  modport sink (input valid, out_sample, output ready);
endinterface

@@ design/sfrc_serial.sv @@
module sfrc_serial (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfrc_pkg::unit_req_t req_i,
  input  logic [63:0]         opa_i,
  input  logic [63:0]         opb_i,
  output sfrc_pkg::unit_rsp_t rsp_o,
  output logic [63:0]         res_o
);
  import sfrc_pkg::*;

  logic [63:0]           r_q, r_d, s_q, s_d, t_q, t_d;
  logic [UNIT_CNT_W-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d, done_q, done_d;
  unit_op_e              op_q, op_d;
  logic [64:0]           rem_sh;
  logic                  ge;

  always_comb begin
    rem_sh = {r_q, s_q[63]};
    ge     = rem_sh >= {1'b0, t_q};
    r_d    = r_q;
    s_d    = s_q;
    t_d    = t_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    op_d   = op_q;
    done_d = 1'b0;
    if (req_i.start) begin
      op_d   = req_i.op;
      r_d    = '0;
      s_d    = opa_i;
      t_d    = opb_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (op_q == OP_MUL) begin
        // shift-add, one multiplier bit a cycle
        r_d = r_q + (t_q[0] ? s_q : 64'd0);
        s_d = {s_q[62:0], 1'b0};
        t_d = {1'b0, t_q[63:1]};
      end else begin
        // restoring division, one quotient bit a cycle
        r_d = ge ? 64'(rem_sh - {1'b0, t_q}) : rem_sh[63:0];
        s_d = {s_q[62:0], ge};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == UNIT_CNT_W'(UNIT_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    s_q <= s_d;
    t_q <= t_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign res_o      = (op_q == OP_MUL) ? r_q : s_q;

endmodule

@@ design/sample_filter_resonator_clip.sv @@
// Voice post-processing: one-pole filter, two-pole resonator, gain and clip.
// in_i takes one request per sample (sample, cutoff, resonator frequency and
// amount); out_o gives one gained and clipped sample per request, filtered
// and resonated as the mode and enable registers select. Registers are
// written through cfg_we_i/cfg_idx_i/cfg_data_i; the user is to write them
// only while idle, which the block itself does not enforce: 0 filter mode,
// 1 resonator enable, 2 output gain, 3 clip level. All multiplies and
// divides run on one shared bit-serial unit. A bypassed sample with the
// resonator off needs one pass. The filter adds six passes, the resonator
// up to 32 more (its cosine and sine series alone twenty).
// One sample is in work at a time; in_i.ready is high only between samples.
// The result sits in an output register, so the next request is taken while
// it waits; a stalled receiver holds the block only when a second result
// is ready before the first has gone.
// Reset clears the filter and resonator state to zero, sets the gain to
// unity and the clip level to 262144 (2^18) and leaves the output empty.
`include "sample_filter_resonator_clip_defines.svh"

module sample_filter_resonator_clip (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sfrc_in_if.sink                        in_i,
  sfrc_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [sfrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sfrc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sfrc_pkg::*;

  logic [1:0]  mode_q;
  logic        reso_en_q;
  logic [15:0] gain_q;
  logic [22:0] clip_q;

  step_e step_q, step_d;
  logic  phase_q, phase_d;

  logic signed [31:0] x_q, x_d;
  logic [15:0]        cut_q, cut_d, rf_q, rf_d, ra_q, ra_d;
  logic signed [31:0] pin_q, pin_d, pout_q, pout_d, pos_q, pos_d, vel_q, vel_d;
  logic [35:0]        fc_q, fc_d;
  logic signed [31:0] a0_q, a0_d, b1_q, b1_d;
  logic signed [63:0] acc_q, acc_d;
  logic [27:0]        rw_q, rw_d;
  logic [24:0]        inv_q, inv_d;
  logic [31:0]        turns_q, turns_d;
  logic signed [31:0] q_q, q_d, r_q, r_d, c_q, c_d, cw_q, cw_d;
  logic [29:0]        cx_q, cx_d, x2_q, x2_d;
  logic [30:0]        ser_q, ser_d, cs_q, cs_d;
  logic [63:0]        t_q, t_d;
  logic [SERIES_W-1:0] k_q, k_d;
  logic               sin_q, sin_d;
  logic signed [23:0] g_q, g_d, out_q, out_d;
  logic               out_valid_q, out_valid_d;

  unit_req_t   req;
  unit_rsp_t   rsp;
  logic [63:0] opa, opb, p;
  logic        use_unit, fin;

  logic [63:0]        fden, dmag, nmag, iv_den;
  logic               dneg;
  logic signed [63:0] rden, quot, t2, gs, lim;
  logic signed [31:0] d_s, pos_new;
  logic [1:0]         quad;
  logic [29:0]        u, v;
  logic               swap;
  logic [30:0]        cbv, sbv;
  logic [24:0]        cbr, sbr;
  logic [30:0]        ser_new;

  sfrc_serial u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .opa_i  (opa),
    .opb_i  (opb),
    .rsp_o  (rsp),
    .res_o  (p)
  );

  always_comb begin
    fden    = 64'(fc_q) + W_FILT;
    dneg    = 64'(fc_q) > W_FILT;
    dmag    = dneg ? 64'(fc_q) - W_FILT : W_FILT - 64'(fc_q);
    nmag    = (mode_q == MODE_LOWPASS) ? 64'(fc_q) : W_FILT;
    iv_den  = ONE_Q24 + 64'(rw_q);
    rden    = $signed((64'(ra_q) << 17) + 64'(inv_q) + 64'(rw_q) - (ONE_Q24 << 1));
    quad    = turns_q[31:30];
    u       = turns_q[29:0];
    swap    = 64'(u) > (ONE_Q30 >> 1);
    v       = swap ? 30'(ONE_Q30 - 64'(u)) : u;
    cbv     = swap ? ser_q : cs_q;
    sbv     = swap ? cs_q : ser_q;
    cbr     = 25'((32'(cbv) + 32'd32) >> 6);
    sbr     = 25'((32'(sbv) + 32'd32) >> 6);
    d_s     = sat32(sx32(x_q) - sx32(pos_q));
    pos_new = sat32(sx32(pos_q) + sx32(vel_q));
    quot    = $signed(p);
    t2      = '0;
    gs      = apply_sign(rnd_u(p, 12), x_q[31]);
    lim     = $signed(64'(clip_q));
    ser_new = 31'(ONE_Q30 - p);

    step_d  = step_q;
    phase_d = phase_q;
    x_d = x_q;  cut_d = cut_q;  rf_d = rf_q;  ra_d = ra_q;
    pin_d = pin_q;  pout_d = pout_q;  pos_d = pos_q;  vel_d = vel_q;
    fc_d = fc_q;  a0_d = a0_q;  b1_d = b1_q;  acc_d = acc_q;
    rw_d = rw_q;  inv_d = inv_q;  turns_d = turns_q;
    q_d = q_q;  r_d = r_q;  c_d = c_q;  cw_d = cw_q;
    cx_d = cx_q;  x2_d = x2_q;  ser_d = ser_q;  cs_d = cs_q;
    t_d = t_q;  k_d = k_q;  sin_d = sin_q;  g_d = g_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    use_unit = 1'b0;
    req.op   = OP_MUL;
    opa      = '0;
    opb      = '0;
    fin      = phase_q && rsp.done;

    unique case (step_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          x_d   = 32'(in_i.in_sample);
          cut_d = in_i.cutoff_freq;
          rf_d  = in_i.reso_freq;
          ra_d  = in_i.reso_amount;
          if (mode_q == MODE_LOWPASS || mode_q == MODE_HIGHPASS) begin
            step_d = ST_F_FC;
          end else if (reso_en_q) begin
            step_d = ST_R_W;
          end else begin
            step_d = ST_G_MUL;
          end
        end
      end
      ST_F_FC: begin
        use_unit = 1'b1;
        opa      = 64'(cut_q);
        opb      = TWO_PI_Q16;
        if (fin) begin
          fc_d   = p[35:0];
          step_d = ST_F_B1;
        end
      end
      ST_F_B1: begin
        use_unit = 1'b1;
        req.op   = OP_DIV;
        opa      = (dmag << 24) + (fden >> 1);
        opb      = fden;
        if (fin) begin
          b1_d   = 32'(apply_sign(p, dneg));
          step_d = ST_F_A0;
        end
      end
      ST_F_A0: begin
        use_unit = 1'b1;
        req.op   = OP_DIV;
        opa      = (nmag << 24) + (fden >> 1);
        opb      = fden;
        if (fin) begin
          a0_d   = $signed(p[31:0]);
          step_d = ST_F_M0;
        end
      end
      ST_F_M0: begin
        use_unit = 1'b1;
        opa      = abs64(sx32(pin_q));
        opb      = abs64(sx32(a0_q));
        if (fin) begin
          acc_d  = apply_sign(p, pin_q[31]);
          step_d = ST_F_M1;
        end
      end
      ST_F_M1: begin
        use_unit = 1'b1;
        opa      = abs64(sx32(x_q));
        opb      = abs64(sx32(a0_q));
        if (fin) begin
          acc_d  = acc_q + apply_sign(p, x_q[31] ^ (mode_q == MODE_HIGHPASS));
          step_d = ST_F_M2;
        end
      end
      ST_F_M2: begin
        use_unit = 1'b1;
        opa      = abs64(sx32(pout_q));
        opb      = abs64(sx32(b1_q));
        if (fin) begin
          acc_d  = acc_q + apply_sign(p, pout_q[31] ^ b1_q[31]);
          step_d = ST_F_Y;
        end
      end
      ST_F_Y: begin
        pin_d  = x_q;
        pout_d = sat32(apply_sign(rnd_u(abs64(acc_q), 24), acc_q[63]));
        x_d    = sat32(apply_sign(rnd_u(abs64(acc_q), 24), acc_q[63]));
        step_d = reso_en_q ? ST_R_W : ST_G_MUL;
      end
      ST_R_W: begin
        use_unit = 1'b1;
        opa      = 64'(rf_q);
        opb      = TWO_PI_Q24;
        if (fin) begin
          t_d    = p;
          step_d = ST_R_WD;
        end
      end
      ST_R_WD: begin
        use_unit = 1'b1;
        req.op   = OP_DIV;
        opa      = t_q + HALF_SR;
        opb      = SR;
        if (fin) begin
          rw_d   = p[27:0];
          step_d = ST_R_INV;
        end
      end
      ST_R_INV: begin
        use_unit = 1'b1;
        req.op   = OP_DIV;
        opa      = (64'd1 << 48) + (iv_den >> 1);
        opb      = iv_den;
        if (fin) begin
          inv_d  = p[24:0];
          step_d = ST_R_TURN;
        end
      end
      ST_R_TURN: begin
        use_unit = 1'b1;
        req.op   = OP_DIV;
        opa      = (64'(rf_q) << 32) + HALF_SR;
        opb      = SR;
        if (fin) begin
          turns_d = p[31:0];
          step_d  = ST_R_QUOT;
        end
      end
      ST_R_QUOT: begin
        if (rden == 64'sd0) begin
          // zero divisor: quotient pinned by whether the angle is nonzero
          q_d    = sat32($signed(ONE_Q24) - ((rw_q != '0) ? 64'sd2147483647 : 64'sd0));
          step_d = ST_R_R;
        end else begin
          use_unit = 1'b1;
          req.op   = OP_DIV;
          opa      = 64'(rw_q) << 24;
          opb      = abs64(rden);
          quot     = sx32(sat32(apply_sign(p, rden[63])));
          if (fin) begin
            q_d    = sat32($signed(ONE_Q24) - quot);
            step_d = ST_R_R;
          end
        end
      end
      ST_R_R: begin
        use_unit = 1'b1;
        opa      = abs64(sx32(q_q));
        opb      = abs64(sx32(q_q));
        if (fin) begin
          r_d    = sat32($signed(rnd_u(p, 24)));
          step_d = ST_C_X;
        end
      end
      ST_C_X: begin
        use_unit = 1'b1;
        opa      = 64'(v);
        opb      = HALF_PI_Q30;
        if (fin) begin
          cx_d   = 30'(rnd_u(p, 30));
          step_d = ST_C_X2;
        end
      end
      ST_C_X2: begin
        use_unit = 1'b1;
        opa      = 64'(cx_q);
        opb      = 64'(cx_q);
        if (fin) begin
          x2_d   = 30'(p >> 30);
          ser_d  = 31'(ONE_Q30);
          k_d    = '0;
          sin_d  = 1'b0;
          step_d = ST_C_MUL;
        end
      end
      ST_C_MUL: begin
        use_unit = 1'b1;
        opa      = 64'(x2_q);
        opb      = 64'(ser_q);
        if (fin) begin
          t_d    = p >> 30;
          step_d = ST_C_DIV;
        end
      end
      ST_C_DIV: begin
        use_unit = 1'b1;
        req.op   = OP_DIV;
        opa      = t_q;
        opb      = series_div(sin_q, k_q);
        if (fin) begin
          ser_d  = ser_new;
          step_d = ST_C_MUL;
          if (k_q == SERIES_W'(SERIES_TERMS - 1)) begin
            if (!sin_q) begin
              cs_d  = ser_new;
              ser_d = 31'(ONE_Q30);
              sin_d = 1'b1;
              k_d   = '0;
            end else begin
              step_d = ST_C_SX;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_C_SX: begin
        use_unit = 1'b1;
        opa      = 64'(cx_q);
        opb      = 64'(ser_q);
        if (fin) begin
          ser_d  = 31'(p >> 30);
          step_d = ST_C_FIN;
        end
      end
      ST_C_FIN: begin
        unique case (quad)
          2'd0:    cw_d = $signed(32'(cbr));
          2'd1:    cw_d = -$signed(32'(sbr));
          2'd2:    cw_d = -$signed(32'(cbr));
          default: cw_d = $signed(32'(sbr));
        endcase
        step_d = ST_R_C;
      end
      ST_R_C: begin
        use_unit = 1'b1;
        opa      = abs64(sx32(cw_q));
        opb      = abs64(sx32(q_q));
        t2       = apply_sign(rnd_u(p, 24), cw_q[31] ^ q_q[31]);
        if (fin) begin
          c_d    = sat32(sx32(r_q) + $signed(ONE_Q24) - (t2 <<< 1));
          step_d = ST_R_V1;
        end
      end
      ST_R_V1: begin
        use_unit = 1'b1;
        opa      = abs64(sx32(d_s));
        opb      = abs64(sx32(c_q));
        if (fin) begin
          vel_d  = sat32(sx32(vel_q) + apply_sign(rnd_u(p, 24), d_s[31] ^ c_q[31]));
          step_d = ST_R_P;
        end
      end
      ST_R_P: begin
        pos_d  = pos_new;
        x_d    = pos_new;
        step_d = ST_R_V2;
      end
      ST_R_V2: begin
        use_unit = 1'b1;
        opa      = abs64(sx32(vel_q));
        opb      = abs64(sx32(r_q));
        if (fin) begin
          vel_d  = sat32(apply_sign(rnd_u(p, 24), vel_q[31] ^ r_q[31]));
          step_d = ST_G_MUL;
        end
      end
      ST_G_MUL: begin
        use_unit = 1'b1;
        opa      = abs64(sx32(x_q));
        opb      = 64'(gain_q);
        if (fin) begin
          if (gs > lim) begin
            g_d = 24'(lim);
          end else if (gs < -lim) begin
            g_d = 24'(-lim);
          end else begin
            g_d = 24'(gs);
          end
          step_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = g_q;
          out_valid_d = 1'b1;
          step_d      = ST_IDLE;
        end
      end
      default: begin
        step_d = ST_IDLE;
      end
    endcase

    req.start = use_unit && !phase_q;
    if (req.start) begin
      phase_d = 1'b1;
    end else if (fin) begin
      phase_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      pin_q       <= '0;
      pout_q      <= '0;
      pos_q       <= '0;
      vel_q       <= '0;
    end else begin
      step_q      <= step_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      pin_q       <= pin_d;
      pout_q      <= pout_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;  cut_q <= cut_d;  rf_q <= rf_d;  ra_q <= ra_d;
    fc_q <= fc_d;  a0_q <= a0_d;  b1_q <= b1_d;  acc_q <= acc_d;
    rw_q <= rw_d;  inv_q <= inv_d;  turns_q <= turns_d;
    q_q <= q_d;  r_q <= r_d;  c_q <= c_d;  cw_q <= cw_d;
    cx_q <= cx_d;  x2_q <= x2_d;  ser_q <= ser_d;  cs_q <= cs_d;
    t_q <= t_d;  k_q <= k_d;  sin_q <= sin_d;  g_q <= g_d;
    out_q <= out_d;
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      reso_en_q <= 1'b0;
      gain_q    <= 16'd4096;
      clip_q    <= 23'd262144;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FILTER_MODE: mode_q    <= cfg_data_i[1:0];
        CFG_RESO_EN:     reso_en_q <= cfg_data_i[0];
        CFG_GAIN:        gain_q    <= cfg_data_i[15:0];
        CFG_CLIP:        clip_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_i.ready       = (step_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.out_sample = out_q;

  `SFRC_ASSERT_IMP(a_idle_unit_free, step_q == ST_IDLE, !rsp.busy && !phase_q, "unit busy while idle")
  `SFRC_ASSERT_IMP(a_start_free, req.start, !rsp.busy, "unit started while busy")
  `SFRC_ASSERT_IMP(a_done_launched, rsp.done, phase_q, "unit result without a launch")
  `SFRC_ASSERT_NXT(a_accept_busy, in_i.valid && in_i.ready, step_q != ST_IDLE, "request lost")

endmodule

@@ sim/sample_filter_resonator_clip_tb.sv @@
module sample_filter_resonator_clip_tb;
  import sfrc_pkg::*;

  localparam longint CYCLE_LIMIT = 30_000_000;
  localparam int SETTLE_CYCLES = 3000;
  localparam logic [1:0] MODE_BYPASS = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic signed [23:0] sample;
    logic [15:0]        cutoff;
    logic [15:0]        rfreq;
    logic [15:0]        ramount;
  } voice_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sfrc_in_if  in_bus ();
  sfrc_out_if out_bus ();

  sample_filter_resonator_clip u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  voice_req_t pending_reqs[$];
  logic signed [23:0] expected_samples[$];
  int  errors = 0;
  bit  idle_on = 1'b1;
  bit  long_stall_req = 1'b0;
  longint cycles = 0;

  // register shadows and filter/resonator state of the predictor
  logic [1:0]  sh_mode;
  logic        sh_reso_en;
  logic [15:0] sh_gain;
  logic [22:0] sh_clip;
  longint fil_x1, fil_y1, res_pos, res_vel;

  function automatic longint sat_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_shift(longint v, int n);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + (64'd1 << (n - 1))) >> n;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint unsigned m;
    m = (num < 0) ? longint'(-num) : num;
    m = (m + longint'(den) / 2) / longint'(den);
    return (num < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint cosine_q24(logic [31:0] phase);
    longint u, v, x, x2, cs, sn, cb, sb;
    bit swap;
    u = longint'(phase[29:0]);
    swap = u > 64'sd536870912;
    v = swap ? 64'sd1073741824 - u : u;
    x = (v * 64'sd1686629713 + 64'sd536870912) >>> 30;
    x2 = (x * x) >>> 30;
    cs = 64'sd1073741824;
    sn = 64'sd1073741824;
    for (int k = 10; k >= 2; k -= 2)
      cs = 64'sd1073741824 - ((x2 * cs) >>> 30) / (k * (k - 1));
    for (int k = 11; k >= 3; k -= 2)
      sn = 64'sd1073741824 - ((x2 * sn) >>> 30) / (k * (k - 1));
    sn = (x * sn) >>> 30;
    cb = ((swap ? sn : cs) + 32) >>> 6;
    sb = ((swap ? cs : sn) + 32) >>> 6;
    case (phase[31:30])
      2'd0: return cb;
      2'd1: return -sb;
      2'd2: return -cb;
      default: return sb;
    endcase
  endfunction

  function automatic longint one_pole(longint x, logic [15:0] cutoff);
    longint fc, w, den, a0, a1, b1, y;
    fc = longint'(cutoff) * 411774;
    w = 64'sd88200 << 16;
    den = fc + w;
    b1 = round_div((w - fc) * 64'sd16777216, den);
    if (sh_mode == MODE_LOWPASS) begin
      a0 = round_div(fc * 64'sd16777216, den);
      a1 = a0;
    end else begin
      a0 = round_div(w * 64'sd16777216, den);
      a1 = -a0;
    end
    y = sat_s32(round_shift(fil_x1 * a0 + x * a1 + fil_y1 * b1, 24));
    fil_x1 = x;
    fil_y1 = y;
    return y;
  endfunction

  function automatic longint two_pole(longint x, logic [15:0] freq, logic [15:0] amount);
    longint w, inv, den, quot, q, r, c, d, vel, pos;
    logic [63:0] turns;
    w = round_div(longint'(freq) * 64'sd105414358, 44100);
    inv = round_div(64'sd1 << 48, 64'sd16777216 + w);
    den = 2 * (longint'(amount) << 16) + inv + w - 64'sd33554432;
    turns = ((64'(freq) << 32) + 64'd22050) / 64'd44100;
    if (den == 0) quot = (w > 0) ? 64'sd2147483647 : 0;
    else quot = sat_s32((w * 64'sd16777216) / den);
    q = sat_s32(64'sd16777216 - quot);
    r = sat_s32(round_shift(q * q, 24));
    c = sat_s32(r + 64'sd16777216 - 2 * round_shift(cosine_q24(turns[31:0]) * q, 24));
    d = sat_s32(x - res_pos);
    vel = sat_s32(res_vel + round_shift(d * c, 24));
    pos = sat_s32(res_pos + vel);
    vel = sat_s32(round_shift(vel * r, 24));
    res_pos = pos;
    res_vel = vel;
    return pos;
  endfunction

  function automatic logic signed [23:0] voice_output(voice_req_t req);
    longint f, lim;
    f = longint'(req.sample);
    lim = longint'(sh_clip);
    if (sh_mode == MODE_LOWPASS || sh_mode == MODE_HIGHPASS) f = one_pole(f, req.cutoff);
    if (sh_reso_en) f = two_pole(f, req.rfreq, req.ramount);
    f = round_shift(f * longint'(sh_gain), 12);
    if (f > lim) f = lim;
    if (f < -lim) f = -lim;
    return f[23:0];
  endfunction

  // request driver and predictor
  int tx_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.in_sample <= '0;
      in_bus.cutoff_freq <= '0;
      in_bus.reso_freq <= '0;
      in_bus.reso_amount <= '0;
      tx_gap <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        voice_req_t acc;
        acc = '{in_bus.in_sample, in_bus.cutoff_freq, in_bus.reso_freq, in_bus.reso_amount};
        expected_samples.push_back(voice_output(acc));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          tx_gap <= $urandom_range(1, 14) - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          voice_req_t nx;
          nx = pending_reqs.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.in_sample <= nx.sample;
          in_bus.cutoff_freq <= nx.cutoff;
          in_bus.reso_freq <= nx.rfreq;
          in_bus.reso_amount <= nx.ramount;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  int rx_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      rx_gap <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample, expected none, actual %0d", $time,
                   out_bus.out_sample);
          errors++;
        end else begin
          logic signed [23:0] exp_s;
          exp_s = expected_samples.pop_front();
          if (out_bus.out_sample !== exp_s) begin
            $display("%0t: out_sample mismatch, expected %0d, actual %0d", $time,
                     exp_s, out_bus.out_sample);
            errors++;
          end
        end
      end
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        rx_gap <= 1500;
        out_bus.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        rx_gap <= $urandom_range(1, 14) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FILTER_MODE: sh_mode = val[1:0];
      CFG_RESO_EN:     sh_reso_en = val[0];
      CFG_GAIN:        sh_gain = val[15:0];
      default:         sh_clip = val[22:0];
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_bus.valid || expected_samples.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic configure(logic [1:0] mode, logic reso, logic [15:0] gain, logic [22:0] clip);
    write_reg(CFG_FILTER_MODE, 23'(mode));
    write_reg(CFG_RESO_EN, 23'(reso));
    write_reg(CFG_GAIN, 23'(gain));
    write_reg(CFG_CLIP, clip);
  endtask

  function automatic voice_req_t random_req();
    voice_req_t r;
    r.sample = 24'($urandom());
    if ($urandom_range(0, 3) == 0) r.sample = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
    r.cutoff = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 4000));
    r.rfreq = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 3000));
    case ($urandom_range(0, 3))
      0: r.ramount = 16'($urandom());
      1: r.ramount = 16'd128;
      default: r.ramount = 16'($urandom_range(0, 600));
    endcase
    return r;
  endfunction

  task automatic add_random(int n);
    repeat (n) pending_reqs.push_back(random_req());
  endtask

  initial begin
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    sh_mode = MODE_BYPASS;
    sh_reso_en = 1'b0;
    sh_gain = 16'd4096;
    sh_clip = 23'd262144;
    fil_x1 = 0;
    fil_y1 = 0;
    res_pos = 0;
    res_vel = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset settings, then extremes of every field and mode
    pending_reqs.push_back('{24'sh7fffff, 16'd0, 16'd0, 16'd0});
    pending_reqs.push_back('{24'sh800000, 16'hffff, 16'hffff, 16'hffff});
    drain();
    configure(MODE_LOWPASS, 1'b0, 16'hffff, 23'h7fffff);
    pending_reqs.push_back('{24'sh7fffff, 16'd0, 16'd0, 16'd0});
    pending_reqs.push_back('{24'sh7fffff, 16'hffff, 16'd0, 16'd0});
    pending_reqs.push_back('{24'sh800000, 16'd1000, 16'd0, 16'd0});
    drain();
    configure(MODE_HIGHPASS, 1'b1, 16'd4096, 23'h7fffff);
    pending_reqs.push_back('{24'sh7fffff, 16'd0, 16'd0, 16'd128});
    pending_reqs.push_back('{24'sh800000, 16'hffff, 16'hffff, 16'hffff});
    pending_reqs.push_back('{24'sh400000, 16'd500, 16'd440, 16'd0});
    pending_reqs.push_back('{24'sh000000, 16'd500, 16'd11025, 16'd256});
    drain();
    configure(MODE_SPARE, 1'b1, 16'd0, 23'd0);
    pending_reqs.push_back('{24'sh7fffff, 16'd300, 16'd1000, 16'd300});
    pending_reqs.push_back('{24'sh800000, 16'd300, 16'd22050, 16'd300});
    drain();
    configure(MODE_BYPASS, 1'b0, 16'd8192, 23'd100000);
    pending_reqs.push_back('{24'sh123456, 16'd0, 16'd0, 16'd0});
    drain();

    // random phases; long receiver stall in a fast bypass phase fills the block
    configure(MODE_BYPASS, 1'b0, 16'($urandom()), 23'($urandom()));
    add_random(300);
    repeat (200) @(posedge clk_i);
    long_stall_req = 1'b1;
    drain();
    configure(MODE_LOWPASS, 1'b0, 16'd4096, 23'h7fffff);
    add_random(300);
    drain();
    configure(MODE_HIGHPASS, 1'b0, 16'($urandom()), 23'($urandom()));
    add_random(300);
    drain();
    configure(MODE_LOWPASS, 1'b1, 16'd4096, 23'h7fffff);
    add_random(200);
    drain();
    configure(MODE_SPARE, 1'b1, 16'hffff, 23'($urandom()));
    add_random(150);
    drain();
    configure(MODE_HIGHPASS, 1'b1, 16'd2048, 23'h400000);
    add_random(150);
    drain();
    configure(MODE_BYPASS, 1'b1, 16'd0, 23'h7fffff);
    add_random(50);
    drain();
    idle_on = 1'b0;
    configure(MODE_LOWPASS, 1'b0, 16'($urandom()), 23'h7fffff);
    add_random(380);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
